FILE: src/szhp_pkg.sv
// ----------------------------------------------------------------------------
// szhp_pkg
// Shared types and constants of the 7z next-header parser.
// ----------------------------------------------------------------------------
package szhp_pkg;

    localparam int unsigned SIZE_LIMIT_DEF = 33554432;
    localparam int unsigned MAX_NAME_DEF   = 256;
    localparam int unsigned CFG_W          = 26;
    localparam int unsigned SZ_W           = 26;

    localparam logic CFG_IDX_NAME_CAP   = 1'b0;
    localparam logic CFG_IDX_PACK_LIMIT = 1'b1;

    localparam logic [7:0] LZMA2_ID      = 8'h21;
    localparam logic [7:0] NAME_PROP_ID  = 8'd17;
    localparam logic [7:0] DICT_PROP_MAX = 8'd40;

    // one queued byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } szhp_byte_t;

    // one result item
    typedef struct packed {
        logic            kind;
        logic [7:0]      name_char;
        logic            name_restart;
        logic            ok;
        logic [SZ_W-1:0] packed_size;
        logic [SZ_W-1:0] unpacked_size;
        logic [5:0]      dict_property;
        logic [31:0]     stream_crc;
        logic            crc_present;
    } szhp_result_t;

endpackage

FILE: src/szhp_if.sv
// ----------------------------------------------------------------------------
// szhp_in_if / szhp_out_if
// Valid/ready channels of the header parser.
// ----------------------------------------------------------------------------
interface szhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       last;
    modport source (output valid, output header_byte, output last, input ready);
    modport sink   (input valid, input header_byte, input last, output ready);
endinterface

interface szhp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  name_char;
    logic        name_restart;
    logic        ok;
    logic [25:0] packed_size;
    logic [25:0] unpacked_size;
    logic [5:0]  dict_property;
    logic [31:0] stream_crc;
    logic        crc_present;
    modport source (output valid, output kind, output name_char, output name_restart,
                    output ok, output packed_size, output unpacked_size,
                    output dict_property, output stream_crc, output crc_present,
                    input ready);
    modport sink   (input valid, input kind, input name_char, input name_restart,
                    input ok, input packed_size, input unpacked_size,
                    input dict_property, input stream_crc, input crc_present,
                    output ready);
endinterface

FILE: src/sevenz_single_lzma2_header_parser_top.sv
// ----------------------------------------------------------------------------
// sevenz_single_lzma2_header_parser_top
// Streaming 7z next-header parser for one LZMA2 stream and one file.
// ----------------------------------------------------------------------------
// data path: a byte is written into a two-entry queue; the engine takes it from
// there and registers any result, so the queue entry and the result register
// lie between a byte transfer and the result transfer it causes
// throughput: one byte per cycle while the output register is empty or being taken
// reset: asynchronous, clears parse state, queue and output valid; the
// registers return to name_capacity 256 and pack_area_limit 2^25
module sevenz_single_lzma2_header_parser_top
    import szhp_pkg::*;
#(
    parameter int unsigned SIZE_LIMIT = SIZE_LIMIT_DEF,
    parameter int unsigned MAX_NAME   = MAX_NAME_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    szhp_in_if.sink          in_ch,
    szhp_out_if.source       out_ch
);

    localparam int unsigned NC_W = $clog2(MAX_NAME) + 1;

    logic [8:0]      cap_reg;
    logic [SZ_W-1:0] limit_reg;
    logic            q_full, q_empty, take;
    szhp_byte_t      q_wr, q_rd;
    szhp_result_t    r;
    logic            r_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 9'd256;
            limit_reg <= SZ_W'(33554432);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_NAME_CAP:   cap_reg   <= cfg_data[8:0];
                CFG_IDX_PACK_LIMIT: limit_reg <= cfg_data[SZ_W-1:0];
                default:            ;
            endcase
        end
    end

    assign in_ch.ready = !q_full;
    assign q_wr.data   = in_ch.header_byte;
    assign q_wr.last   = in_ch.last;

    szhp_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_ch.valid && !q_full),
        .wr_data (q_wr),
        .full    (q_full),
        .rd_en   (take),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    szhp_engine #(
        .SIZE_LIMIT (SIZE_LIMIT),
        .MAX_NAME   (MAX_NAME)
    ) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (!q_empty),
        .byte_in    (q_rd),
        .byte_take  (take),
        .name_cap   ((cap_reg > 9'(MAX_NAME)) ? NC_W'(MAX_NAME) : NC_W'(cap_reg)),
        .pack_limit (limit_reg),
        .res_valid  (r_valid),
        .res        (r),
        .res_ready  (out_ch.ready)
    );

    assign out_ch.valid         = r_valid;
    assign out_ch.kind          = r.kind;
    assign out_ch.name_char     = r.name_char;
    assign out_ch.name_restart  = r.name_restart;
    assign out_ch.ok            = r.ok;
    assign out_ch.packed_size   = r.packed_size;
    assign out_ch.unpacked_size = r.unpacked_size;
    assign out_ch.dict_property = r.dict_property;
    assign out_ch.stream_crc    = r.stream_crc;
    assign out_ch.crc_present   = r.crc_present;

endmodule

FILE: src/szhp_fifo.sv
// ----------------------------------------------------------------------------
// szhp_fifo
// Two-entry byte queue between the intake and the parse engine.
// ----------------------------------------------------------------------------
module szhp_fifo
    import szhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  szhp_byte_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output szhp_byte_t rd_data,
    output logic       empty
);

    szhp_byte_t mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + 1'b1;
        rp_next  = rp_reg + 1'b1;
        cnt_next = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_next;
            end
            if (rd_en)
            begin
                rp_reg <= rp_next;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: src/szhp_engine.sv
// ----------------------------------------------------------------------------
// szhp_engine
// Header state machine: number decode, tag checks, name streaming, summary.
// ----------------------------------------------------------------------------
module szhp_engine
    import szhp_pkg::*;
#(
    parameter int unsigned SIZE_LIMIT = SIZE_LIMIT_DEF,
    parameter int unsigned MAX_NAME   = MAX_NAME_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    input  szhp_byte_t                   byte_in,
    output logic                         byte_take,
    input  logic [$clog2(MAX_NAME):0]    name_cap,
    input  logic [SZ_W-1:0]              pack_limit,
    output logic                         res_valid,
    output szhp_result_t                 res,
    input  logic                         res_ready
);

    localparam int unsigned NL_W = $clog2(MAX_NAME) + 1;

    typedef enum logic [38:0] {
        PH_HDR         = 39'd1 << 0,
        PH_MAIN        = 39'd1 << 1,
        PH_PACK_ID     = 39'd1 << 2,
        PH_PACK_POS    = 39'd1 << 3,
        PH_PACK_NUM    = 39'd1 << 4,
        PH_PACK_LOOP   = 39'd1 << 5,
        PH_PACK_SIZE   = 39'd1 << 6,
        PH_PACK_DEF    = 39'd1 << 7,
        PH_PACK_CRC    = 39'd1 << 8,
        PH_UNP_ID      = 39'd1 << 9,
        PH_FOLDER      = 39'd1 << 10,
        PH_NFOLD       = 39'd1 << 11,
        PH_EXT         = 39'd1 << 12,
        PH_NCODERS     = 39'd1 << 13,
        PH_FLAGS       = 39'd1 << 14,
        PH_METHOD      = 39'd1 << 15,
        PH_PROPSZ      = 39'd1 << 16,
        PH_PROP        = 39'd1 << 17,
        PH_SIZES_ID    = 39'd1 << 18,
        PH_UNP_SIZE    = 39'd1 << 19,
        PH_UNP_LOOP    = 39'd1 << 20,
        PH_UNP_DEF     = 39'd1 << 21,
        PH_UNP_CRC     = 39'd1 << 22,
        PH_SUB_ID      = 39'd1 << 23,
        PH_SUB_LOOP    = 39'd1 << 24,
        PH_SUB_DEF     = 39'd1 << 25,
        PH_SUB_CRC     = 39'd1 << 26,
        PH_STREAMS_END = 39'd1 << 27,
        PH_FILES_ID    = 39'd1 << 28,
        PH_NFILES      = 39'd1 << 29,
        PH_FILE_LOOP   = 39'd1 << 30,
        PH_PSZ_NAME    = 39'd1 << 31,
        PH_PSZ_OTHER   = 39'd1 << 32,
        PH_NAME_EXT    = 39'd1 << 33,
        PH_NAME_LO     = 39'd1 << 34,
        PH_NAME_HI     = 39'd1 << 35,
        PH_SKIP_PROP   = 39'd1 << 36,
        PH_END         = 39'd1 << 37,
        PH_DONE        = 39'd1 << 38
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [63:0]     acc_reg, acc_next;
    logic [3:0]      nleft_reg, nleft_next;
    logic [2:0]      npos_reg, npos_next;
    logic [SZ_W-1:0] pleft_reg, pleft_next;
    logic [2:0]      skip_reg, skip_next;
    logic [NL_W-1:0] nlen_reg, nlen_next;
    logic [7:0]      held_reg, held_next;
    logic            ndone_reg, ndone_next;
    logic            saw_reg, saw_next;
    logic [SZ_W-1:0] packed_reg, packed_next;
    logic [SZ_W-1:0] unpacked_reg, unpacked_next;
    logic [5:0]      prop_reg, prop_next;
    logic [31:0]     crc_reg, crc_next;
    logic            crcs_reg, crcs_next;
    logic            fail_reg, fail_next;
    logic            rvalid_reg, rvalid_next;
    szhp_result_t    res_reg, res_next;

    logic            is_num;
    logic            num_done;
    logic [63:0]     num_val;
    logic [3:0]      extra;
    logic [7:0]      lowmask;
    logic            emit;
    logic [7:0]      emit_val;
    logic            emit_rst;
    logic [SZ_W-1:0] pl_dec;
    logic [NL_W-1:0] cap;
    logic            big;
    logic [7:0]      b;

    // output stage frees when empty or taken this cycle
    assign byte_take = byte_valid && (!rvalid_reg || res_ready);
    assign res_valid = rvalid_reg;
    assign res       = res_reg;
    assign b         = byte_in.data;
    assign cap       = (name_cap < NL_W'(MAX_NAME)) ? name_cap : NL_W'(MAX_NAME);
    assign pl_dec    = pleft_reg - 1'b1;
    assign big       = (num_val > 64'(SIZE_LIMIT));

    always_comb
    begin
        is_num = 1'b0;
        case (phase_reg)
            PH_PACK_POS, PH_PACK_NUM, PH_PACK_SIZE, PH_NFOLD, PH_NCODERS,
            PH_PROPSZ, PH_UNP_SIZE, PH_NFILES, PH_PSZ_NAME, PH_PSZ_OTHER:
                is_num = 1'b1;
            default: is_num = 1'b0;
        endcase
    end

    // leading-ones count of the first number byte
    always_comb
    begin
        extra   = 4'd8;
        lowmask = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            if (!b[i] && extra == 4'd8)
            begin
                extra   = 4'(7 - i);
                lowmask = 8'((9'd1 << i) - 9'd1);
            end
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        nleft_next    = nleft_reg;
        npos_next     = npos_reg;
        pleft_next    = pleft_reg;
        skip_next     = skip_reg;
        nlen_next     = nlen_reg;
        held_next     = held_reg;
        ndone_next    = ndone_reg;
        saw_next      = saw_reg;
        packed_next   = packed_reg;
        unpacked_next = unpacked_reg;
        prop_next     = prop_reg;
        crc_next      = crc_reg;
        crcs_next     = crcs_reg;
        fail_next     = fail_reg;
        num_done      = 1'b0;
        num_val       = 64'd0;
        emit          = 1'b0;
        emit_val      = 8'd0;
        emit_rst      = 1'b0;

        if (!fail_reg && is_num)
        begin
            if (nleft_reg == 4'd0)
            begin
                acc_next = (extra == 4'd8) ? 64'd0 : (64'(b & lowmask) << {extra[2:0], 3'b000});
                if (extra == 4'd0)
                begin
                    num_done = 1'b1;
                    num_val  = acc_next;
                end
                else
                begin
                    nleft_next = extra;
                    npos_next  = 3'd0;
                end
            end
            else
            begin
                acc_next   = acc_reg | (64'(b) << {npos_reg, 3'b000});
                npos_next  = npos_reg + 1'b1;
                nleft_next = nleft_reg - 1'b1;
                if (nleft_reg == 4'd1)
                begin
                    num_done = 1'b1;
                    num_val  = acc_next;
                end
            end
            if (num_done)
            begin
                case (phase_reg)
                    PH_PACK_POS:
                        if (num_val == 64'd0) phase_next = PH_PACK_NUM; else fail_next = 1'b1;
                    PH_PACK_NUM:
                        if (num_val == 64'd1) phase_next = PH_PACK_LOOP; else fail_next = 1'b1;
                    PH_PACK_SIZE:
                        if (num_val == 64'd0 || big) fail_next = 1'b1;
                        else
                        begin
                            packed_next = num_val[SZ_W-1:0];
                            phase_next  = PH_PACK_LOOP;
                        end
                    PH_NFOLD:
                        if (num_val == 64'd1) phase_next = PH_EXT; else fail_next = 1'b1;
                    PH_NCODERS:
                        if (num_val == 64'd1) phase_next = PH_FLAGS; else fail_next = 1'b1;
                    PH_PROPSZ:
                        if (num_val == 64'd1) phase_next = PH_PROP; else fail_next = 1'b1;
                    PH_UNP_SIZE:
                        if (num_val == 64'd0 || big) fail_next = 1'b1;
                        else
                        begin
                            unpacked_next = num_val[SZ_W-1:0];
                            phase_next    = PH_UNP_LOOP;
                        end
                    PH_NFILES:
                        if (num_val == 64'd1) phase_next = PH_FILE_LOOP; else fail_next = 1'b1;
                    PH_PSZ_NAME:
                        if (num_val == 64'd0 || big) fail_next = 1'b1;
                        else
                        begin
                            pleft_next = num_val[SZ_W-1:0];
                            phase_next = PH_NAME_EXT;
                        end
                    default:
                        if (big) fail_next = 1'b1;
                        else
                        begin
                            pleft_next = num_val[SZ_W-1:0];
                            phase_next = (num_val == 64'd0) ? PH_FILE_LOOP : PH_SKIP_PROP;
                        end
                endcase
            end
        end
        else if (!fail_reg)
        begin
            case (phase_reg)
                PH_HDR:      if (b == 8'd1) phase_next = PH_MAIN; else fail_next = 1'b1;
                PH_MAIN:     if (b == 8'd4) phase_next = PH_PACK_ID; else fail_next = 1'b1;
                PH_PACK_ID:  if (b == 8'd6) phase_next = PH_PACK_POS; else fail_next = 1'b1;
                PH_PACK_LOOP:
                    if (b == 8'd0)
                    begin
                        if (packed_reg != '0) phase_next = PH_UNP_ID; else fail_next = 1'b1;
                    end
                    else if (b == 8'd9)  phase_next = PH_PACK_SIZE;
                    else if (b == 8'd10) phase_next = PH_PACK_DEF;
                    else fail_next = 1'b1;
                PH_PACK_DEF, PH_UNP_DEF, PH_SUB_DEF:
                begin
                    skip_next = 3'd4;
                    if (b != 8'd1) fail_next = 1'b1;
                    else if (phase_reg == PH_PACK_DEF) phase_next = PH_PACK_CRC;
                    else if (phase_reg == PH_UNP_DEF)  phase_next = PH_UNP_CRC;
                    else phase_next = PH_SUB_CRC;
                end
                PH_PACK_CRC:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 3'd1) phase_next = PH_PACK_LOOP;
                end
                PH_UNP_CRC, PH_SUB_CRC:
                begin
                    case (2'(3'd4 - skip_reg))
                        2'd0: crc_next = {24'd0, b};
                        2'd1: crc_next = crc_reg | {16'd0, b, 8'd0};
                        2'd2: crc_next = crc_reg | {8'd0, b, 16'd0};
                        default: crc_next = crc_reg | {b, 24'd0};
                    endcase
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 3'd1)
                    begin
                        crcs_next  = 1'b1;
                        phase_next = (phase_reg == PH_UNP_CRC) ? PH_UNP_LOOP : PH_SUB_LOOP;
                    end
                end
                PH_UNP_ID:   if (b == 8'd7)  phase_next = PH_FOLDER; else fail_next = 1'b1;
                PH_FOLDER:   if (b == 8'd11) phase_next = PH_NFOLD; else fail_next = 1'b1;
                PH_EXT:      if (b == 8'd0)  phase_next = PH_NCODERS; else fail_next = 1'b1;
                PH_FLAGS:    if (b == LZMA2_ID) phase_next = PH_METHOD; else fail_next = 1'b1;
                PH_METHOD:   if (b == LZMA2_ID) phase_next = PH_PROPSZ; else fail_next = 1'b1;
                PH_PROP:
                    if (b > DICT_PROP_MAX) fail_next = 1'b1;
                    else
                    begin
                        prop_next  = b[5:0];
                        phase_next = PH_SIZES_ID;
                    end
                PH_SIZES_ID: if (b == 8'd12) phase_next = PH_UNP_SIZE; else fail_next = 1'b1;
                PH_UNP_LOOP:
                    if (b == 8'd0) phase_next = PH_SUB_ID;
                    else if (b == 8'd10) phase_next = PH_UNP_DEF;
                    else fail_next = 1'b1;
                PH_SUB_ID:   if (b == 8'd8) phase_next = PH_SUB_LOOP; else fail_next = 1'b1;
                PH_SUB_LOOP:
                    if (b == 8'd0) phase_next = PH_STREAMS_END;
                    else if (b == 8'd10) phase_next = PH_SUB_DEF;
                    else fail_next = 1'b1;
                PH_STREAMS_END: if (b == 8'd0) phase_next = PH_FILES_ID; else fail_next = 1'b1;
                PH_FILES_ID: if (b == 8'd5) phase_next = PH_NFILES; else fail_next = 1'b1;
                PH_FILE_LOOP:
                    if (b == 8'd0)
                    begin
                        if (saw_reg) phase_next = PH_END; else fail_next = 1'b1;
                    end
                    else phase_next = (b == NAME_PROP_ID) ? PH_PSZ_NAME : PH_PSZ_OTHER;
                PH_NAME_EXT, PH_NAME_HI:
                begin
                    pleft_next = pl_dec;
                    if (phase_reg == PH_NAME_EXT)
                    begin
                        if (b != 8'd0) fail_next = 1'b1;
                        nlen_next  = '0;
                        ndone_next = 1'b0;
                        saw_next   = 1'b0;
                    end
                    else if (held_reg == 8'd0 && b == 8'd0) ndone_next = 1'b1;
                    else if (b != 8'd0 || (nlen_reg + 1'b1) >= cap) fail_next = 1'b1;
                    else
                    begin
                        emit      = 1'b1;
                        emit_val  = held_reg;
                        emit_rst  = (nlen_reg == '0);
                        nlen_next = nlen_reg + 1'b1;
                        saw_next  = 1'b1;
                    end
                    if (pl_dec == '0) phase_next = PH_FILE_LOOP;
                    else if (ndone_next || pl_dec < SZ_W'(2)) phase_next = PH_SKIP_PROP;
                    else phase_next = PH_NAME_LO;
                end
                PH_NAME_LO:
                begin
                    held_next  = b;
                    pleft_next = pl_dec;
                    phase_next = PH_NAME_HI;
                end
                PH_SKIP_PROP:
                begin
                    pleft_next = pl_dec;
                    if (pl_dec == '0) phase_next = PH_FILE_LOOP;
                end
                PH_END: if (b == 8'd0) phase_next = PH_DONE; else fail_next = 1'b1;
                default: fail_next = 1'b1;
            endcase
        end

        rvalid_next = rvalid_reg && !res_ready;
        res_next    = res_reg;
        if (byte_take)
        begin
            res_next    = '0;
            rvalid_next = 1'b0;
            if (byte_in.last)
            begin
                rvalid_next   = 1'b1;
                res_next.kind = 1'b1;
                if (!fail_next && phase_next == PH_DONE && packed_next <= pack_limit)
                begin
                    res_next.ok            = 1'b1;
                    res_next.packed_size   = packed_next;
                    res_next.unpacked_size = unpacked_next;
                    res_next.dict_property = prop_next;
                    res_next.stream_crc    = crc_next;
                    res_next.crc_present   = crcs_next;
                end
            end
            else if (emit && !fail_next)
            begin
                rvalid_next           = 1'b1;
                res_next.name_char    = emit_val;
                res_next.name_restart = emit_rst;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            acc_reg      <= '0;
            nleft_reg    <= '0;
            npos_reg     <= '0;
            pleft_reg    <= '0;
            skip_reg     <= '0;
            nlen_reg     <= '0;
            held_reg     <= '0;
            ndone_reg    <= 1'b0;
            saw_reg      <= 1'b0;
            packed_reg   <= '0;
            unpacked_reg <= '0;
            prop_reg     <= '0;
            crc_reg      <= '0;
            crcs_reg     <= 1'b0;
            fail_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            if (byte_take)
            begin
                if (byte_in.last)
                begin
                    // summary sent, start over
                    phase_reg    <= PH_HDR;
                    acc_reg      <= '0;
                    nleft_reg    <= '0;
                    npos_reg     <= '0;
                    pleft_reg    <= '0;
                    skip_reg     <= '0;
                    nlen_reg     <= '0;
                    held_reg     <= '0;
                    ndone_reg    <= 1'b0;
                    saw_reg      <= 1'b0;
                    packed_reg   <= '0;
                    unpacked_reg <= '0;
                    prop_reg     <= '0;
                    crc_reg      <= '0;
                    crcs_reg     <= 1'b0;
                    fail_reg     <= 1'b0;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    acc_reg      <= acc_next;
                    nleft_reg    <= nleft_next;
                    npos_reg     <= npos_next;
                    pleft_reg    <= pleft_next;
                    skip_reg     <= skip_next;
                    nlen_reg     <= nlen_next;
                    held_reg     <= held_next;
                    ndone_reg    <= ndone_next;
                    saw_reg      <= saw_next;
                    packed_reg   <= packed_next;
                    unpacked_reg <= unpacked_next;
                    prop_reg     <= prop_next;
                    crc_reg      <= crc_next;
                    crcs_reg     <= crcs_next;
                    fail_reg     <= fail_next;
                end
            end
        end
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 7z next-header parser. A directed table and
// randomized headers (well-formed, corrupted, cut short, noise) are streamed
// with random bursts and output stalls; every transfer out is compared field
// by field against an in-bench model of the parse state machine.
// ----------------------------------------------------------------------------
module tb
    import szhp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam longint unsigned SZ_MAX   = 64'd33554432;

    typedef enum logic [5:0] {
        S_HDR, S_MAIN, S_PACK_ID, S_PACK_POS, S_PACK_NUM, S_PACK_LOOP,
        S_PACK_SIZE, S_PACK_DEF, S_PACK_CRC, S_UNP_ID, S_FOLDER, S_NFOLD,
        S_EXT, S_NCODERS, S_FLAGS, S_METHOD, S_PROPSZ, S_PROP, S_SIZES_ID,
        S_UNP_SIZE, S_UNP_LOOP, S_UNP_DEF, S_UNP_CRC, S_SUB_ID, S_SUB_LOOP,
        S_SUB_DEF, S_SUB_CRC, S_STREAMS_END, S_FILES_ID, S_NFILES,
        S_FILE_LOOP, S_PSZ_NAME, S_PSZ_OTHER, S_NAME_EXT, S_NAME_LO,
        S_NAME_HI, S_SKIP_PROP, S_END, S_DONE
    } parse_st_t;

    typedef struct {
        szhp_byte_t b;
        int         row;
    } tx_item_t;

    typedef struct {
        logic [7:0]   data;
        logic         last;
        bit           typed;
        szhp_result_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    szhp_in_if  in_if ();
    szhp_out_if out_if ();

    sevenz_single_lzma2_header_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    // header parser model state
    parse_st_t   st;
    logic [63:0] num_acc;
    int unsigned num_left;
    int unsigned num_pos;
    int unsigned prop_left;
    int unsigned skip_cnt;
    int unsigned name_len;
    logic [7:0]  held_lo;
    bit          name_done;
    bit          name_seen;
    logic [25:0] packed_val;
    logic [25:0] unpacked_val;
    logic [5:0]  dict_val;
    logic [31:0] crc_val;
    bit          crc_seen;
    bit          failed;
    bit          char_out;
    logic [7:0]  char_val;
    bit          char_first;
    int unsigned name_cap_reg;
    int unsigned pack_limit_reg;

    tx_item_t     tx_q[$];
    szhp_result_t result_q[$];
    dir_row_t     dir_tab[$];

    int unsigned cycles;
    int unsigned fail_cnt;
    int unsigned bytes_sent;
    int unsigned chars_seen;
    int unsigned good_hdrs;
    int unsigned bad_hdrs;
    int unsigned burst_left;
    int unsigned gap_left;
    bit          gapless;
    int unsigned rx_mode;
    int unsigned rx_cnt;

    function automatic void clear_parse();
        st = S_HDR;
        num_acc = '0; num_left = 0; num_pos = 0; prop_left = 0; skip_cnt = 0;
        name_len = 0; held_lo = '0; name_done = 0; name_seen = 0;
        packed_val = '0; unpacked_val = '0; dict_val = '0; crc_val = '0;
        crc_seen = 0; failed = 0;
    endfunction

    function automatic void need(logic [7:0] b, logic [7:0] want, parse_st_t nxt);
        if (b == want) st = nxt;
        else failed = 1;
    endfunction

    function automatic void need_one(logic [63:0] v, parse_st_t nxt);
        if (v == 64'd1) st = nxt;
        else failed = 1;
    endfunction

    function automatic void name_step();
        if (prop_left == 0) st = S_FILE_LOOP;
        else if (name_done || prop_left < 2) st = S_SKIP_PROP;
        else st = S_NAME_LO;
    endfunction

    function automatic void take_number(logic [63:0] v);
        case (st)
            S_PACK_POS: if (v == 0) st = S_PACK_NUM; else failed = 1;
            S_PACK_NUM: need_one(v, S_PACK_LOOP);
            S_PACK_SIZE:
                if (v == 0 || v > SZ_MAX) failed = 1;
                else begin packed_val = v[25:0]; st = S_PACK_LOOP; end
            S_NFOLD:    need_one(v, S_EXT);
            S_NCODERS:  need_one(v, S_FLAGS);
            S_PROPSZ:   need_one(v, S_PROP);
            S_UNP_SIZE:
                if (v == 0 || v > SZ_MAX) failed = 1;
                else begin unpacked_val = v[25:0]; st = S_UNP_LOOP; end
            S_NFILES:   need_one(v, S_FILE_LOOP);
            S_PSZ_NAME:
                if (v == 0 || v > SZ_MAX) failed = 1;
                else begin prop_left = v[31:0]; st = S_NAME_EXT; end
            S_PSZ_OTHER:
                if (v > SZ_MAX) failed = 1;
                else begin
                    prop_left = v[31:0];
                    st = (v == 0) ? S_FILE_LOOP : S_SKIP_PROP;
                end
            default: failed = 1;
        endcase
    endfunction

    function automatic void number_byte(logic [7:0] b);
        int unsigned extra;
        logic [7:0]  mask;
        extra = 0;
        mask = 8'h80;
        if (num_left == 0) begin
            while (extra < 8 && (b & mask) != 0) begin
                extra++;
                mask = mask >> 1;
            end
            num_acc = (extra < 8) ? (64'(b & (mask - 8'd1)) << (extra * 8)) : 64'd0;
            if (extra == 0) take_number(num_acc);
            else begin
                num_left = extra;
                num_pos = 0;
            end
        end else begin
            num_acc = num_acc | (64'(b) << ((num_pos & 7) * 8));
            num_pos++;
            num_left--;
            if (num_left == 0) take_number(num_acc);
        end
    endfunction

    function automatic void crc_byte(logic [7:0] b, parse_st_t back);
        int unsigned idx;
        idx = (4 - skip_cnt) & 3;
        if (idx == 0) crc_val = 32'(b);
        else crc_val = crc_val | (32'(b) << (idx * 8));
        skip_cnt--;
        if (skip_cnt == 0) begin crc_seen = 1; st = back; end
    endfunction

    function automatic void consume(logic [7:0] b);
        int unsigned cap;
        if (st inside {S_PACK_POS, S_PACK_NUM, S_PACK_SIZE, S_NFOLD, S_NCODERS,
                       S_PROPSZ, S_UNP_SIZE, S_NFILES, S_PSZ_NAME, S_PSZ_OTHER}) begin
            number_byte(b);
            return;
        end
        case (st)
            S_HDR:     need(b, 8'd1, S_MAIN);
            S_MAIN:    need(b, 8'd4, S_PACK_ID);
            S_PACK_ID: need(b, 8'd6, S_PACK_POS);
            S_PACK_LOOP:
                if (b == 0) begin
                    if (packed_val != 0) st = S_UNP_ID; else failed = 1;
                end else if (b == 8'd9) st = S_PACK_SIZE;
                else if (b == 8'd10) st = S_PACK_DEF;
                else failed = 1;
            S_PACK_DEF: begin skip_cnt = 4; need(b, 8'd1, S_PACK_CRC); end
            S_PACK_CRC: begin skip_cnt--; if (skip_cnt == 0) st = S_PACK_LOOP; end
            S_UNP_ID:  need(b, 8'd7, S_FOLDER);
            S_FOLDER:  need(b, 8'd11, S_NFOLD);
            S_EXT:     need(b, 8'd0, S_NCODERS);
            S_FLAGS:   need(b, LZMA2_ID, S_METHOD);
            S_METHOD:  need(b, LZMA2_ID, S_PROPSZ);
            S_PROP:
                if (b > DICT_PROP_MAX) failed = 1;
                else begin dict_val = b[5:0]; st = S_SIZES_ID; end
            S_SIZES_ID: need(b, 8'd12, S_UNP_SIZE);
            S_UNP_LOOP: if (b == 0) st = S_SUB_ID; else need(b, 8'd10, S_UNP_DEF);
            S_UNP_DEF:  begin skip_cnt = 4; need(b, 8'd1, S_UNP_CRC); end
            S_UNP_CRC:  crc_byte(b, S_UNP_LOOP);
            S_SUB_ID:   need(b, 8'd8, S_SUB_LOOP);
            S_SUB_LOOP: if (b == 0) st = S_STREAMS_END; else need(b, 8'd10, S_SUB_DEF);
            S_SUB_DEF:  begin skip_cnt = 4; need(b, 8'd1, S_SUB_CRC); end
            S_SUB_CRC:  crc_byte(b, S_SUB_LOOP);
            S_STREAMS_END: need(b, 8'd0, S_FILES_ID);
            S_FILES_ID: need(b, 8'd5, S_NFILES);
            S_FILE_LOOP:
                if (b == 0) begin
                    if (name_seen) st = S_END; else failed = 1;
                end else st = (b == NAME_PROP_ID) ? S_PSZ_NAME : S_PSZ_OTHER;
            S_NAME_EXT:
                if (b != 0) failed = 1;
                else begin
                    prop_left--;
                    name_len = 0; name_done = 0; name_seen = 0;
                    name_step();
                end
            S_NAME_LO: begin held_lo = b; prop_left--; st = S_NAME_HI; end
            S_NAME_HI: begin
                prop_left--;
                cap = (name_cap_reg < MAX_NAME_DEF) ? name_cap_reg : MAX_NAME_DEF;
                if (held_lo == 0 && b == 0) begin
                    name_done = 1;
                    name_step();
                end else if (b != 0 || name_len + 1 >= cap) failed = 1;
                else begin
                    char_out = 1; char_val = held_lo; char_first = (name_len == 0);
                    name_len++; name_seen = 1;
                    name_step();
                end
            end
            S_SKIP_PROP: begin prop_left--; if (prop_left == 0) st = S_FILE_LOOP; end
            S_END: need(b, 8'd0, S_DONE);
            default: failed = 1;
        endcase
    endfunction

    // advance the model by one byte, returns 1 if a result transfer follows
    function automatic bit parse_byte(logic [7:0] b, logic last, output szhp_result_t r);
        r = '0;
        char_out = 0; char_val = '0; char_first = 0;
        if (!failed) consume(b);
        if (last) begin
            r.kind = 1'b1;
            if (!failed && st == S_DONE && packed_val <= pack_limit_reg) begin
                r.ok = 1'b1;
                r.packed_size = packed_val;
                r.unpacked_size = unpacked_val;
                r.dict_property = dict_val;
                r.stream_crc = crc_val;
                r.crc_present = crc_seen;
            end
            clear_parse();
            return 1;
        end
        if (char_out && !failed) begin
            r.name_char = char_val;
            r.name_restart = char_first;
            return 1;
        end
        return 0;
    endfunction

    function automatic void check_field(string fname, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s mismatch: expected %0h actual %0h", fname, e, a);
            fail_cnt++;
        end
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_IDX_NAME_CAP;
        cfg_data = '0;
        in_if.valid = 0;
        in_if.header_byte = '0;
        in_if.last = 0;
        out_if.ready = 0;
    end

    // sender, model update on accepted bytes, output check
    always @(posedge clk or negedge rst_n) begin
        tx_item_t     it;
        szhp_result_t r;
        szhp_result_t e;
        bit           got;
        if (!rst_n) begin
            in_if.valid <= 0;
            out_if.ready <= 0;
            cycles <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL sevenz_single_lzma2_header_parser_top");
                $finish;
            end
            if (in_if.valid && in_if.ready) begin
                it = tx_q.pop_front();
                bytes_sent++;
                got = parse_byte(it.b.data, it.b.last, r);
                if (it.row >= 0 && dir_tab[it.row].typed) begin
                    if (!got || r != dir_tab[it.row].res) begin
                        $error("table row %0d: model disagrees with typed result", it.row);
                        fail_cnt++;
                    end
                    r = dir_tab[it.row].res;
                    got = 1;
                end
                if (got) result_q.push_back(r);
            end
            // hold the byte while stalled
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    in_if.valid <= 0;
                    gap_left <= gap_left - 1;
                end else if (tx_q.size() != 0) begin
                    in_if.valid <= 1;
                    in_if.header_byte <= tx_q[0].b.data;
                    in_if.last <= tx_q[0].b.last;
                    if (burst_left == 0) begin
                        gapless = ($urandom_range(0, 3) == 0);
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= gapless ? 0 : $urandom_range(0, 5);
                    end else burst_left <= burst_left - 1;
                end else in_if.valid <= 0;
            end
            // receiver stall pattern
            if (rx_cnt % 80 == 0) rx_mode = $urandom_range(0, 2);
            rx_cnt++;
            case (rx_mode)
                0: out_if.ready <= 1;
                1: out_if.ready <= ($urandom_range(0, 9) < 7);
                default: out_if.ready <= ((rx_cnt % 9) < 2);
            endcase
            if (out_if.valid && out_if.ready) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_cnt++;
                end else begin
                    e = result_q.pop_front();
                    check_field("kind", e.kind, out_if.kind);
                    check_field("name_char", e.name_char, out_if.name_char);
                    check_field("name_restart", e.name_restart, out_if.name_restart);
                    check_field("ok", e.ok, out_if.ok);
                    check_field("packed_size", e.packed_size, out_if.packed_size);
                    check_field("unpacked_size", e.unpacked_size, out_if.unpacked_size);
                    check_field("dict_property", e.dict_property, out_if.dict_property);
                    check_field("stream_crc", e.stream_crc, out_if.stream_crc);
                    check_field("crc_present", e.crc_present, out_if.crc_present);
                    if (e.kind) begin
                        if (e.ok) good_hdrs++; else bad_hdrs++;
                    end else chars_seen++;
                end
            end
        end
    end

    function automatic void put(ref logic [7:0] q[$], input logic [7:0] b);
        q.push_back(b);
    endfunction

    // 7z number, sometimes with one byte more than needed, rarely with all eight extra bytes
    function automatic void put_num(ref logic [7:0] q[$], input logic [63:0] v);
        int unsigned n;
        int unsigned i;
        logic [63:0] hi;
        n = 0;
        while (n < 7 && (v >> (8 * n)) >= (64'd1 << (7 - n))) n++;
        if (n == 7 && (v >> 56) != 0) n = 8;
        if (n < 8 && $urandom_range(0, 4) == 0) n++;
        if ($urandom_range(0, 30) == 0) n = 8;
        hi = (n == 8) ? 64'd0 : (v >> (8 * n));
        q.push_back(8'(16'hFF00 >> n) | 8'(hi));
        for (i = 0; i < n; i++) q.push_back(8'(v >> (8 * i)));
    endfunction

    function automatic logic [63:0] pick_size();
        case ($urandom_range(0, 7))
            0: return SZ_MAX;
            1: return 64'd1;
            2: return 64'($urandom_range(1, 33554432));
            default: return 64'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic void put_crc_entries(ref logic [7:0] q[$], input int unsigned n);
        int unsigned i;
        int unsigned k;
        for (i = 0; i < n; i++) begin
            put(q, 8'd10);
            put(q, 8'd1);
            for (k = 0; k < 4; k++) put(q, 8'($urandom));
        end
    endfunction

    function automatic void put_name(ref logic [7:0] q[$]);
        logic [7:0]  body[$];
        int unsigned k;
        int unsigned i;
        k = ($urandom_range(0, 12) == 0) ? $urandom_range(200, 260) : $urandom_range(1, 8);
        for (i = 0; i < k; i++) begin
            body.push_back(8'($urandom_range(1, 255)));
            body.push_back(($urandom_range(0, 60) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
        end
        if ($urandom_range(0, 4) == 0) begin
            body.push_back(8'd0);
            body.push_back(8'd0);
            for (i = $urandom_range(0, 3); i > 0; i--) body.push_back(8'($urandom));
        end
        if ($urandom_range(0, 5) == 0) body.push_back(8'($urandom));
        put(q, NAME_PROP_ID);
        if ($urandom_range(0, 30) == 0) begin
            put_num(q, 64'd0);
            return;
        end
        put_num(q, 64'(body.size() + 1));
        put(q, ($urandom_range(0, 30) == 0) ? 8'd1 : 8'd0);
        foreach (body[i]) put(q, body[i]);
    endfunction

    function automatic void build_header(ref logic [7:0] q[$]);
        int unsigned n;
        int unsigned i;
        int unsigned k;
        logic [7:0]  id;
        put(q, 8'd1); put(q, 8'd4); put(q, 8'd6);
        put_num(q, 64'd0); put_num(q, 64'd1);
        n = $urandom_range(0, 2);
        put(q, 8'd9); put_num(q, pick_size());
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) begin put(q, 8'd9); put_num(q, pick_size()); end
            else put_crc_entries(q, 1);
        end
        put(q, 8'd0);
        put(q, 8'd7); put(q, 8'd11); put_num(q, 64'd1); put(q, 8'd0); put_num(q, 64'd1);
        put(q, LZMA2_ID); put(q, LZMA2_ID); put_num(q, 64'd1);
        put(q, 8'($urandom_range(0, 40)));
        put(q, 8'd12); put_num(q, pick_size());
        put_crc_entries(q, $urandom_range(0, 2)); put(q, 8'd0);
        put(q, 8'd8);
        put_crc_entries(q, $urandom_range(0, 2)); put(q, 8'd0);
        put(q, 8'd0); put(q, 8'd5); put_num(q, 64'd1);
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                do id = 8'($urandom); while (id == 0 || id == NAME_PROP_ID);
                put(q, id);
                k = $urandom_range(0, 4);
                put_num(q, 64'(k));
                for (; k > 0; k--) put(q, 8'($urandom));
            end else put_name(q);
        end
        put(q, 8'd0); put(q, 8'd0);
    endfunction

    task automatic queue_bytes(ref logic [7:0] q[$]);
        tx_item_t it;
        @(negedge clk);
        foreach (q[i]) begin
            it.b.data = q[i];
            it.b.last = (i == q.size() - 1);
            it.row = -1;
            tx_q.push_back(it);
        end
    endtask

    // one header, intact or damaged, or a short burst of noise
    task automatic queue_random_header(output int unsigned cnt);
        logic [7:0]  q[$];
        int unsigned sel;
        int unsigned i;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            for (i = $urandom_range(1, 6); i > 0; i--) q.push_back(8'($urandom));
        end else begin
            build_header(q);
            if (sel < 22) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            else if (sel < 30) q = q[0:$urandom_range(0, q.size() - 2)];
            else if (sel < 34) q.push_back(8'($urandom));
        end
        cnt = q.size();
        queue_bytes(q);
    endtask

    task automatic wait_idle();
        wait (tx_q.size() == 0 && result_q.size() == 0);
        // bytes with no result may still sit in the input queue
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_IDX_NAME_CAP) name_cap_reg = val[8:0];
        else pack_limit_reg = val;
    endtask

    task automatic add_row(logic [7:0] d, logic l, bit typed, szhp_result_t r);
        dir_row_t row;
        row.data = d; row.last = l; row.typed = typed; row.res = r;
        dir_tab.push_back(row);
    endtask

    initial begin
        szhp_result_t none;
        szhp_result_t r;
        logic [7:0]   hdr[$];
        tx_item_t     it;
        int unsigned  budget;
        int unsigned  cnt;
        int unsigned  ph;

        fail_cnt = 0; bytes_sent = 0; chars_seen = 0; good_hdrs = 0; bad_hdrs = 0;
        rx_mode = 0; rx_cnt = 0; gapless = 0;
        name_cap_reg = MAX_NAME_DEF;
        pack_limit_reg = SIZE_LIMIT_DEF;
        clear_parse();

        repeat (4) @(posedge clk);
        rst_n <= 1;

        // directed: lone bytes that end a header at once, then a minimal header
        none = '0;
        r = '0; r.kind = 1'b1;
        add_row(8'h00, 1, 1, r);
        add_row(8'hFF, 1, 1, r);
        hdr = '{8'h01, 8'h04, 8'h06, 8'h00, 8'h01, 8'h09, 8'h05, 8'h00,
                8'h07, 8'h0B, 8'h01, 8'h00, 8'h01, 8'h21, 8'h21, 8'h01, 8'h28,
                8'h0C, 8'h0A, 8'h00, 8'h08, 8'h00, 8'h00, 8'h05, 8'h01,
                8'h11, 8'h03, 8'h00, 8'h41};
        foreach (hdr[i]) add_row(hdr[i], 0, 0, none);
        r = '0; r.name_char = 8'h41; r.name_restart = 1'b1;
        add_row(8'h00, 0, 1, r);
        add_row(8'h00, 0, 0, none);
        r = '0; r.kind = 1'b1; r.ok = 1'b1; r.packed_size = 26'd5;
        r.unpacked_size = 26'd10; r.dict_property = 6'd40;
        add_row(8'h00, 1, 1, r);

        @(negedge clk);
        foreach (dir_tab[i]) begin
            it.b.data = dir_tab[i].data;
            it.b.last = dir_tab[i].last;
            it.row = i;
            tx_q.push_back(it);
        end
        wait_idle();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_IDX_NAME_CAP, CFG_W'(2));
                    write_reg(CFG_IDX_PACK_LIMIT, CFG_W'(0));
                end
                1: begin
                    write_reg(CFG_IDX_NAME_CAP, CFG_W'(511));
                    write_reg(CFG_IDX_PACK_LIMIT, CFG_W'(SIZE_LIMIT_DEF));
                end
                2: begin
                    write_reg(CFG_IDX_NAME_CAP, CFG_W'($urandom_range(3, 20)));
                    write_reg(CFG_IDX_PACK_LIMIT, CFG_W'($urandom_range(1, 2000)));
                end
                default: begin
                    write_reg(CFG_IDX_NAME_CAP, CFG_W'(256));
                    write_reg(CFG_IDX_PACK_LIMIT, CFG_W'($urandom_range(1000, 33554432)));
                end
            endcase
            budget = 0;
            while (budget < 80) begin
                queue_random_header(cnt);
                budget += cnt;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("%0d header bytes under 5 register settings: %0d accepted headers,",
                 bytes_sent, good_hdrs);
        $display("%0d rejected headers, %0d name characters checked", bad_hdrs, chars_seen);
        if (fail_cnt == 0 && result_q.size() == 0)
            $display("PASS sevenz_single_lzma2_header_parser_top");
        else
            $display("FAIL sevenz_single_lzma2_header_parser_top");
        $finish;
    end

endmodule
